[hdl/vfs_pkg.sv]
// shared types and constants for the virtual sketch spread block
`timescale 1ns / 1ps
package vfs_pkg;
  localparam logic [1:0] REQ_UPDATE = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_SEED   = 2'd2;
  localparam logic CFG_VCOUNT = 1'b0;
  localparam logic CFG_SCOUNT = 1'b1;

  typedef enum logic [2:0] {
    DP_NOP, DP_LOAD, DP_MOD, DP_UPD_SEED, DP_UPD_WR, DP_GLOB, DP_VIRT, DP_SEEDWR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   mod_start;
    logic   clr_sums;
  } dp_cmd_t;

  typedef struct packed {
    logic mod_done;
    logic sweep_last;
    logic clr_done;
  } dp_stat_t;
endpackage

[hdl/vfs_if.sv]
// valid/ready channel interfaces for requests, results and configuration
`timescale 1ns / 1ps
interface vfs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] src_id;
  logic [31:0] dst_id;
  logic [7:0]  seed_index;
  logic [31:0] seed_value;
  modport source (output valid, req_type, src_id, dst_id, seed_index, seed_value,
                  input ready);
  modport sink (input valid, req_type, src_id, dst_id, seed_index, seed_value,
                output ready);
endinterface

interface vfs_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] query_src;
  logic [13:0] virtual_total;
  logic [17:0] global_total;
  modport source (output valid, query_src, virtual_total, global_total, input ready);
  modport sink (input valid, query_src, virtual_total, global_total, output ready);
endinterface

interface vfs_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/vfs_mod.sv]
// restoring bit-serial remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps
module vfs_mod #(
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] rem
);
  logic [31:0]   num_r;
  logic [DW:0]   acc_r;
  logic [5:0]    cnt_r;
  logic          busy_r;
  logic [DW-1:0] den_r;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;

  assign shifted = {acc_r[DW-1:0], num_r[31]};
  assign diff    = shifted - {1'b0, den_r};
  assign rem     = acc_r[DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        num_r  <= dividend;
        den_r  <= divisor;
        acc_r  <= '0;
        cnt_r  <= 6'd0;
      end else if (busy_r) begin
        num_r <= {num_r[30:0], 1'b0};
        acc_r <= diff[DW] ? shifted : diff;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule

[hdl/vfs_datapath.sv]
// sketch and seed memories, remainder unit, sweep counters and sums
`timescale 1ns / 1ps
module vfs_datapath #(
  parameter int SKETCH_DEPTH = 4096,
  parameter int SEED_DEPTH   = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  vfs_pkg::dp_cmd_t cmd,
  output vfs_pkg::dp_stat_t stat,
  input  logic [31:0]      in_src,
  input  logic [31:0]      in_dst,
  input  logic [7:0]       in_sidx,
  input  logic [31:0]      in_sval,
  input  logic             cfg_we,
  input  logic             cfg_idx,
  input  logic [12:0]      cfg_data,
  output logic [31:0]      res_src,
  output logic [13:0]      res_vsum,
  output logic [17:0]      res_gsum
);
  localparam int AW = (SKETCH_DEPTH > 1) ? $clog2(SKETCH_DEPTH) : 1;
  localparam int SW = (SEED_DEPTH > 1) ? $clog2(SEED_DEPTH) : 1;
  localparam int NW = $clog2(SKETCH_DEPTH + 1);
  localparam int VW = $clog2(SEED_DEPTH + 1);
  localparam int DW = (NW > VW) ? NW : VW;

  logic [31:0] sketch_mem [SKETCH_DEPTH];
  logic [31:0] seed_mem [SEED_DEPTH];
  logic [8:0]  vcount_r;
  logic [12:0] scount_r;
  logic [NW-1:0] ns;
  logic [VW-1:0] nv;
  logic [31:0] src_r, dst_r, seed_rd_r, sk_rd_r;
  logic [AW-1:0] addr_r, clr_addr_r, gi_r;
  logic [SW-1:0] vi_r, slot_r;
  logic        clearing_r, clr_done_r;
  logic        mod_go;
  logic [31:0] mod_num;
  logic [DW-1:0] mod_den, mod_rem;
  logic        mod_done;
  logic [4:0]  bitpos;
  logic [5:0]  lo;
  logic [17:0] gsum_r;
  logic [13:0] vsum_r;
  logic [1:0]  phase_r;
  logic        seed_sel_r;

  always_comb begin
    if (scount_r == 13'd0) ns = NW'(1);
    else if (32'(scount_r) > SKETCH_DEPTH) ns = NW'(SKETCH_DEPTH);
    else ns = NW'(scount_r);
    if (vcount_r == 9'd0) nv = VW'(1);
    else if (32'(vcount_r) > SEED_DEPTH) nv = VW'(SEED_DEPTH);
    else nv = VW'(vcount_r);
  end

  // seed phase takes dst mod nv, index phase takes (src^seed) mod ns
  assign mod_go  = cmd.mod_start;
  assign mod_num = seed_sel_r ? (src_r ^ seed_rd_r) : dst_r;
  assign mod_den = seed_sel_r ? DW'(ns) : DW'(nv);

  vfs_mod #(.DW(DW)) u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_go), .dividend(mod_num),
    .divisor(mod_den), .done(mod_done), .rem(mod_rem)
  );

  always_comb begin
    bitpos = 5'd0;
    for (int i = 31; i >= 0; i--) if (dst_r[i]) bitpos = 5'(31 - i);
  end

  always_comb begin
    lo = 6'd32;
    for (int i = 0; i < 32; i++) if (!sk_rd_r[i]) lo = 6'(31 - i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r   <= 9'd256;
      scount_r   <= 13'd4096;
      clearing_r <= 1'b1;
      clr_done_r <= 1'b0;
      clr_addr_r <= '0;
      seed_sel_r <= 1'b0;
      phase_r    <= 2'd0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == vfs_pkg::CFG_VCOUNT) vcount_r <= cfg_data[8:0];
        else scount_r <= cfg_data;
      end
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (32'(clr_addr_r) == SKETCH_DEPTH - 1) begin
          clearing_r <= 1'b0;
          clr_done_r <= 1'b1;
        end
      end
      case (cmd.op)
        vfs_pkg::DP_LOAD: begin
          src_r <= in_src;
          dst_r <= in_dst;
          seed_sel_r <= 1'b0;
          phase_r <= 2'd0;
          gi_r <= '0;
          vi_r <= '0;
        end
        vfs_pkg::DP_MOD: begin
          if (mod_done) begin
            if (!seed_sel_r) slot_r <= SW'(mod_rem);
            else addr_r <= AW'(mod_rem);
          end
        end
        vfs_pkg::DP_UPD_SEED: begin
          // operand select flips with the seed read, ready for the next start
          phase_r <= phase_r + 2'd1;
          if (phase_r == 2'd0) begin
            seed_rd_r  <= seed_mem[slot_r];
            seed_sel_r <= 1'b1;
          end
          if (phase_r == 2'd1) phase_r <= 2'd0;
        end
        vfs_pkg::DP_UPD_WR: begin
          phase_r <= phase_r + 2'd1;
          if (phase_r == 2'd0) sk_rd_r <= sketch_mem[addr_r];
          if (phase_r == 2'd1) begin
            sketch_mem[addr_r] <= sk_rd_r | (32'h1 << bitpos);
            phase_r <= 2'd0;
          end
        end
        vfs_pkg::DP_GLOB: begin
          // read, then accumulate next cycle
          phase_r <= phase_r + 2'd1;
          if (phase_r == 2'd0) sk_rd_r <= sketch_mem[gi_r];
          if (phase_r == 2'd1) begin
            gsum_r  <= gsum_r + 18'(lo);
            gi_r    <= gi_r + AW'(1);
            phase_r <= 2'd0;
          end
        end
        vfs_pkg::DP_VIRT: begin
          phase_r <= phase_r + 2'd1;
          if (phase_r == 2'd0) begin
            seed_rd_r  <= seed_mem[vi_r];
            seed_sel_r <= 1'b1;
          end
          if (phase_r == 2'd1) phase_r <= 2'd2;
          if (phase_r == 2'd2) sk_rd_r <= sketch_mem[addr_r];
          if (phase_r == 2'd3) begin
            vsum_r  <= vsum_r + 14'(lo);
            vi_r    <= vi_r + SW'(1);
            phase_r <= 2'd0;
          end
        end
        vfs_pkg::DP_SEEDWR: begin
          if (32'(in_sidx) < SEED_DEPTH) seed_mem[SW'(in_sidx)] <= in_sval;
        end
        default: ;
      endcase
      if (cmd.clr_sums) begin
        gsum_r <= '0;
        vsum_r <= '0;
      end
    end
    if (clearing_r) sketch_mem[clr_addr_r] <= '0;
  end

  assign stat.mod_done   = mod_done;
  assign stat.clr_done   = clr_done_r;
  assign stat.sweep_last = (cmd.op == vfs_pkg::DP_GLOB) ? (32'(gi_r) == 32'(ns) - 1)
                                                        : (32'(vi_r) == 32'(nv) - 1);
  assign res_src  = src_r;
  assign res_vsum = vsum_r;
  assign res_gsum = gsum_r;
endmodule

[hdl/vfs_ctrl.sv]
// request sequencer for updates, queries and seed writes
`timescale 1ns / 1ps
module vfs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output vfs_pkg::dp_cmd_t  cmd,
  input  vfs_pkg::dp_stat_t stat
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MOD1, S_SEED, S_MOD2, S_WR, S_GLOB, S_VSTART, S_VSEED,
    S_VMOD, S_VRD, S_DONE
  } state_t;

  state_t state_r;
  logic [1:0] cnt_r;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd = '{op: vfs_pkg::DP_NOP, mod_start: 1'b0, clr_sums: 1'b0};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.clr_sums = 1'b1;
          if (in_req == vfs_pkg::REQ_SEED) cmd.op = vfs_pkg::DP_SEEDWR;
          else cmd.op = vfs_pkg::DP_LOAD;
        end
      end
      S_MOD1, S_MOD2: cmd.op = vfs_pkg::DP_MOD;
      S_SEED: cmd.op = vfs_pkg::DP_UPD_SEED;
      S_WR: cmd.op = vfs_pkg::DP_UPD_WR;
      S_GLOB: cmd.op = vfs_pkg::DP_GLOB;
      S_VSEED, S_VRD: cmd.op = vfs_pkg::DP_VIRT;
      S_VMOD: cmd.op = vfs_pkg::DP_MOD;
      default: ;
    endcase
    // kick the remainder unit once its operands are registered
    if (state_r == S_MOD1 && cnt_r == 2'd0) cmd.mod_start = 1'b1;
    if (state_r == S_SEED && cnt_r == 2'd1) cmd.mod_start = 1'b1;
    if (state_r == S_VSEED && cnt_r == 2'd1) cmd.mod_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      out_valid <= 1'b0;
      cnt_r     <= '0;
    end else begin
      case (state_r)
        S_CLEAR: if (stat.clr_done) state_r <= S_IDLE;
        S_IDLE: begin
          cnt_r <= '0;
          if (in_valid) begin
            case (in_req)
              vfs_pkg::REQ_UPDATE: state_r <= S_MOD1;
              vfs_pkg::REQ_QUERY:  state_r <= S_GLOB;
              default:             state_r <= S_IDLE;
            endcase
          end
        end
        S_MOD1: begin
          cnt_r <= 2'd1;
          if (stat.mod_done) begin
            cnt_r   <= '0;
            state_r <= S_SEED;
          end
        end
        S_SEED: begin
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd1) begin
            cnt_r <= '0;
            state_r <= S_MOD2;
          end
        end
        S_MOD2: if (stat.mod_done) state_r <= S_WR;
        S_WR: begin
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd1) begin
            cnt_r <= '0;
            state_r <= S_IDLE;
          end
        end
        S_GLOB: begin
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd1) begin
            cnt_r <= '0;
            if (stat.sweep_last) state_r <= S_VSTART;
          end
        end
        S_VSTART: state_r <= S_VSEED;
        S_VSEED: begin
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd1) begin
            cnt_r <= 2'd2;
            state_r <= S_VMOD;
          end
        end
        S_VMOD: if (stat.mod_done) state_r <= S_VRD;
        S_VRD: begin
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd3) begin
            cnt_r <= '0;
            if (stat.sweep_last) begin
              state_r   <= S_DONE;
              out_valid <= 1'b1;
            end else state_r <= S_VSEED;
          end
        end
        S_DONE: if (out_ready) begin
          out_valid <= 1'b0;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[hdl/virtual_fm_sketch_spread.sv]
// top level of the virtual sketch spread estimator
// channel | dir | transfer carries
// in_     | in  | req_type, src_id, dst_id, seed_index, seed_value
// out_    | out | query_src, virtual_total, global_total
// cfg_    | in  | index (0 virtual count, 1 sketch count), data
// update: two remainders of a 32-bit value on the shared unit
// query: a sweep over the sketch words in use, then per virtual word a seed read, a remainder and a sketch read
// seed write: written as the request is taken; after reset a clearing pass over all SKETCH_DEPTH words
// in_ready stays low while an item is at work or a result waits
`timescale 1ns / 1ps
module virtual_fm_sketch_spread #(
  parameter int SKETCH_DEPTH = 4096,
  parameter int SEED_DEPTH   = 256
) (
  input logic clk,
  input logic rst_n,
  vfs_req_if.sink   in_ch,
  vfs_res_if.source out_ch,
  vfs_cfg_if.sink   cfg_ch
);
  vfs_pkg::dp_cmd_t  cmd;
  vfs_pkg::dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  vfs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_req(in_ch.req_type), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .stat(stat)
  );

  vfs_datapath #(.SKETCH_DEPTH(SKETCH_DEPTH), .SEED_DEPTH(SEED_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_src(in_ch.src_id), .in_dst(in_ch.dst_id), .in_sidx(in_ch.seed_index),
    .in_sval(in_ch.seed_value), .cfg_we(cfg_ch.valid), .cfg_idx(cfg_ch.index),
    .cfg_data(cfg_ch.data), .res_src(out_ch.query_src),
    .res_vsum(out_ch.virtual_total), .res_gsum(out_ch.global_total)
  );
endmodule

[bench/tb_virtual_fm_sketch_spread.sv]
// self-checking testbench for the virtual sketch spread block
`timescale 1ns / 1ps
module tb_virtual_fm_sketch_spread;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int SK_DEPTH = 4096;
  localparam int SD_DEPTH = 256;
  localparam int SETTLE = 120;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  sidx;
    logic [31:0] sval;
  } spread_req_t;

  typedef struct {
    logic [31:0] src;
    logic [13:0] vtotal;
    logic [17:0] gtotal;
  } spread_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  vfs_req_if in_ch();
  vfs_res_if out_ch();
  vfs_cfg_if cfg_ch();

  virtual_fm_sketch_spread dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // predictor state
  logic [31:0] sketch_model [SK_DEPTH];
  logic [31:0] seed_model [SD_DEPTH];
  logic [8:0]  vcount_reg;
  logic [12:0] scount_reg;
  spread_res_t pending_totals[$];
  int errors = 0;
  bit steady = 0;
  logic [31:0] src_pool [8];

  function automatic int unsigned eff_vcount();
    int unsigned v = vcount_reg;
    if (v == 0) v = 1;
    if (v > SD_DEPTH) v = SD_DEPTH;
    return v;
  endfunction

  function automatic int unsigned eff_scount();
    int unsigned v = scount_reg;
    if (v == 0) v = 1;
    if (v > SK_DEPTH) v = SK_DEPTH;
    return v;
  endfunction

  function automatic int unsigned geo_pos(logic [31:0] x);
    int unsigned tz = 0;
    if (x == 0) return 0;
    while (x[tz] == 1'b0) tz++;
    return 31 - tz;
  endfunction

  function automatic int unsigned lead_run(logic [31:0] x);
    int unsigned n = 0;
    while (n < 32 && x[31-n]) n++;
    return n;
  endfunction

  function automatic void apply_req(spread_req_t r);
    int unsigned nv = eff_vcount();
    int unsigned ns = eff_scount();
    int unsigned vsum = 0;
    int unsigned gsum = 0;
    int unsigned idx;
    spread_res_t res;
    case (r.kind)
      vfs_pkg::REQ_UPDATE: begin
        idx = (r.src ^ seed_model[r.dst % nv]) % ns;
        sketch_model[idx][geo_pos(r.dst)] = 1'b1;
      end
      vfs_pkg::REQ_SEED: seed_model[r.sidx] = r.sval;
      vfs_pkg::REQ_QUERY: begin
        for (int unsigned i = 0; i < ns; i++) gsum += lead_run(sketch_model[i]);
        for (int unsigned i = 0; i < nv; i++)
          vsum += lead_run(sketch_model[(r.src ^ seed_model[i]) % ns]);
        if (vsum > 14'h3FFF) vsum = 14'h3FFF;
        if (gsum > 18'h3FFFF) gsum = 18'h3FFFF;
        res.src = r.src;
        res.vtotal = vsum[13:0];
        res.gtotal = gsum[17:0];
        pending_totals.push_back(res);
      end
      default: ;
    endcase
  endfunction

  task automatic send_req(spread_req_t r);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    repeat (gap) @(negedge clk);
    in_ch.req_type = r.kind;
    in_ch.src_id = r.src;
    in_ch.dst_id = r.dst;
    in_ch.seed_index = r.sidx;
    in_ch.seed_value = r.sval;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    apply_req(r);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_cfg(logic idx, logic [12:0] value);
    cfg_ch.index = idx;
    cfg_ch.data = value;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == vfs_pkg::CFG_VCOUNT) vcount_reg = value[8:0];
    else scount_reg = value;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // wait for all results, then let any update still at work finish
  task automatic drain();
    while (pending_totals.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic spread_req_t mk(logic [1:0] k, logic [31:0] s, logic [31:0] d);
    spread_req_t r;
    r.kind = k;
    r.src = s;
    r.dst = d;
    r.sidx = 8'($urandom);
    r.sval = $urandom;
    return r;
  endfunction

  // result side: per-transfer random stall
  int stall_left = 0;
  bit redraw = 0;
  always @(negedge clk) begin
    if (redraw) begin
      stall_left = steady ? 0 : $urandom_range(0, 6);
      redraw = 0;
    end
    out_ch.ready = (stall_left == 0);
    if (stall_left > 0) stall_left--;
  end

  always @(posedge clk) begin
    spread_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      redraw = 1;
      if (pending_totals.size() == 0) begin
        $error("result transfer with nothing expected: src %h", out_ch.query_src);
        errors++;
      end else begin
        e = pending_totals.pop_front();
        if (out_ch.query_src !== e.src) begin
          $error("query_src expected %h got %h", e.src, out_ch.query_src);
          errors++;
        end
        if (out_ch.virtual_total !== e.vtotal) begin
          $error("virtual_total expected %0d got %0d", e.vtotal, out_ch.virtual_total);
          errors++;
        end
        if (out_ch.global_total !== e.gtotal) begin
          $error("global_total expected %0d got %0d", e.gtotal, out_ch.global_total);
          errors++;
        end
      end
    end
  end

  // every slot must hold a seed before any update or query reads it
  task automatic test_seed_fill();
    spread_req_t r;
    for (int i = 0; i < SD_DEPTH; i++) begin
      r = mk(vfs_pkg::REQ_SEED, $urandom, $urandom);
      r.sidx = 8'(i);
      r.sval = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom;
      send_req(r);
    end
  endtask

  task automatic test_directed();
    spread_req_t r;
    drain();
    write_cfg(vfs_pkg::CFG_VCOUNT, 13'd4);
    write_cfg(vfs_pkg::CFG_SCOUNT, 13'd16);
    send_req(mk(vfs_pkg::REQ_UPDATE, 32'h0, 32'h0));
    send_req(mk(vfs_pkg::REQ_UPDATE, 32'hFFFF_FFFF, 32'h1));
    send_req(mk(vfs_pkg::REQ_UPDATE, 32'h0, 32'h8000_0000));
    send_req(mk(vfs_pkg::REQ_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_req(mk(vfs_pkg::REQ_UPDATE, 32'h1234_5678, 32'h0000_0003));
    send_req(mk(REQ_UNUSED, $urandom, $urandom));
    send_req(mk(vfs_pkg::REQ_QUERY, 32'h0, 32'h0));
    send_req(mk(vfs_pkg::REQ_QUERY, 32'hFFFF_FFFF, 32'h0));
    r = mk(vfs_pkg::REQ_SEED, 0, 0);
    r.sidx = 8'd2;
    r.sval = 32'hFFFF_FFFF;
    send_req(r);
    send_req(mk(vfs_pkg::REQ_UPDATE, 32'h1234_5678, 32'h0000_0006));
    send_req(mk(vfs_pkg::REQ_QUERY, 32'h1234_5678, 32'h0));
    // zero registers behave as one
    drain();
    write_cfg(vfs_pkg::CFG_VCOUNT, 13'd0);
    write_cfg(vfs_pkg::CFG_SCOUNT, 13'd0);
    send_req(mk(vfs_pkg::REQ_UPDATE, 32'hFFFF_FFFF, 32'h1));
    send_req(mk(vfs_pkg::REQ_QUERY, 32'h5, 32'h0));
    // oversized registers clamp to the table depths
    drain();
    write_cfg(vfs_pkg::CFG_VCOUNT, 13'd511);
    write_cfg(vfs_pkg::CFG_SCOUNT, 13'h1FFF);
    send_req(mk(vfs_pkg::REQ_UPDATE, 32'hA5A5_A5A5, 32'h2));
    send_req(mk(vfs_pkg::REQ_QUERY, 32'hA5A5_A5A5, 32'h0));
    drain();
    write_cfg(vfs_pkg::CFG_VCOUNT, 13'd256);
    write_cfg(vfs_pkg::CFG_SCOUNT, 13'd4096);
    send_req(mk(vfs_pkg::REQ_QUERY, 32'h0, 32'h0));
  endtask

  task automatic run_phase(int vc, int sc, int n_items);
    spread_req_t r;
    int pick;
    int q_pct;
    drain();
    write_cfg(vfs_pkg::CFG_VCOUNT, 13'(vc));
    write_cfg(vfs_pkg::CFG_SCOUNT, 13'(sc));
    // queries on big settings are slow, so random ones are left out there and one query ends the phase
    q_pct = (vc * 38 + 2 * sc > 2000) ? 0 : 10;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      r = mk(vfs_pkg::REQ_UPDATE,
             ($urandom_range(0, 9) < 7) ? src_pool[$urandom_range(0, 7)] : $urandom,
             $urandom << $urandom_range(0, 31));
      if (pick < q_pct) r.kind = vfs_pkg::REQ_QUERY;
      else if (pick < q_pct + 12) r.kind = vfs_pkg::REQ_SEED;
      else if (pick < q_pct + 16) r.kind = REQ_UNUSED;
      send_req(r);
    end
    if (q_pct == 0) send_req(mk(vfs_pkg::REQ_QUERY, src_pool[0], 32'h0));
  endtask

  task automatic test_random();
    run_phase(1, 1, 150);
    run_phase(2, 3, 250);
    steady = 1;
    run_phase(8, 32, 300);
    steady = 0;
    run_phase(16, 64, 400);
    run_phase(5, 13, 300);
    run_phase(256, 4096, 200);
    run_phase(3, 8191, 150);
    run_phase(0, 0, 150);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = vfs_pkg::REQ_UPDATE;
    in_ch.src_id = '0;
    in_ch.dst_id = '0;
    in_ch.seed_index = '0;
    in_ch.seed_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = vfs_pkg::CFG_VCOUNT;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    foreach (sketch_model[i]) sketch_model[i] = '0;
    foreach (seed_model[i]) seed_model[i] = '0;
    foreach (src_pool[i]) src_pool[i] = $urandom;
    vcount_reg = 9'd256;
    scount_reg = 13'd4096;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_seed_fill();
    test_directed();
    test_random();
    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

[sim.f]
hdl/vfs_pkg.sv
hdl/vfs_if.sv
hdl/vfs_mod.sv
hdl/vfs_datapath.sv
hdl/vfs_ctrl.sv
hdl/virtual_fm_sketch_spread.sv
bench/tb_virtual_fm_sketch_spread.sv
